@@ hw/rtl/mfat_pkg.sv @@
// Shared types and constants for the motor feedback angle tracker.
`default_nettype none
package mfat_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_EMA_WEIGHT = 2'd0;
  localparam logic [1:0] REG_JUMP_THR   = 2'd1;
  localparam logic [1:0] REG_OUT_SPAN   = 2'd2;

  localparam int CFG_W = 30;

  // Reset values and limits
  localparam logic [16:0] WEIGHT_RST = 17'd13107;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic [12:0] THR_RST    = 13'd6827;
  localparam logic [29:0] SPAN_RST   = 30'd40273707;
  localparam logic [29:0] SPAN_MIN   = 30'd256;

  // Dividend bits for the remainder unit: 34-bit magnitude times 256
  localparam int DIV_BITS = 42;

  typedef struct packed {
    logic [3:0]         motor_number;
    logic [12:0]        rotor_angle;
    logic signed [15:0] speed_sample;
    logic signed [15:0] current_sample;
  } in_t;

  typedef struct packed {
    logic [3:0]         motor_out;
    logic signed [23:0] filtered_speed;
    logic signed [15:0] turn_count;
    logic [29:0]        zeroed_angle;
    logic signed [15:0] current_out;
  } out_t;

  typedef struct packed {
    logic load;
    logic mul_new;
    logic mul_old;
    logic update;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic motor_ok;
    logic div_last;
    logic out_busy;
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_NEW,
    ST_MUL_OLD,
    ST_UPDATE,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/mfat_datapath.sv @@
// Datapath: per-motor state, EMA multiplies, turn counter and remainder unit.
`default_nettype none
module mfat_datapath #(
  parameter int MOTOR_COUNT = 8,
  parameter int ANGLE_BITS  = 13
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire  mfat_pkg::in_t      in_data,
  input  wire                      cfg_we,
  input  wire  [1:0]               cfg_index,
  input  wire  [mfat_pkg::CFG_W-1:0] cfg_data,
  input  wire  mfat_pkg::cmd_t     cmd,
  output mfat_pkg::sts_t           sts,
  output logic                     out_valid,
  input  wire                      out_ready,
  output mfat_pkg::out_t           out_data
);

  localparam int IW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam logic [12:0] AMASK = (ANGLE_BITS >= 13) ? 13'h1FFF
                                  : 13'((1 << ANGLE_BITS) - 1);
  localparam int CW = $clog2(mfat_pkg::DIV_BITS);

  // Configuration registers
  logic [16:0] ema_weight;
  logic [12:0] jump_threshold;
  logic [29:0] output_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      ema_weight     <= mfat_pkg::WEIGHT_RST;
      jump_threshold <= mfat_pkg::THR_RST;
      output_span    <= mfat_pkg::SPAN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mfat_pkg::REG_EMA_WEIGHT: ema_weight     <= cfg_data[16:0];
        mfat_pkg::REG_JUMP_THR:   jump_threshold <= cfg_data[12:0];
        mfat_pkg::REG_OUT_SPAN:   output_span    <= cfg_data[29:0];
        default: ;
      endcase
    end
  end

  logic [16:0] w_eff;
  logic [12:0] thr_eff;
  logic [29:0] span_eff;
  assign w_eff    = (ema_weight > mfat_pkg::WEIGHT_ONE) ? mfat_pkg::WEIGHT_ONE : ema_weight;
  assign thr_eff  = (jump_threshold == 13'd0) ? 13'd1 : jump_threshold;
  assign span_eff = (output_span < mfat_pkg::SPAN_MIN) ? mfat_pkg::SPAN_MIN : output_span;

  // Per-motor state
  logic signed [23:0] speed_average  [MOTOR_COUNT];
  logic [12:0]        previous_angle [MOTOR_COUNT];
  logic [15:0]        turns          [MOTOR_COUNT];
  logic signed [32:0] zero_offset    [MOTOR_COUNT];
  logic               started        [MOTOR_COUNT];

  // Request capture
  mfat_pkg::in_t req;
  logic [IW-1:0] idx;
  logic [4:0]    num_ext;
  assign num_ext = {1'b0, in_data.motor_number};
  assign sts.motor_ok = (num_ext != 5'd0) && (num_ext <= 5'(MOTOR_COUNT));

  // Arithmetic registers
  logic signed [33:0] prod_new;
  logic signed [41:0] prod_old;
  logic signed [23:0] avg_res;
  logic               neg;
  logic [mfat_pkg::DIV_BITS-1:0] dividend;
  logic [29:0]        rem;
  logic [CW-1:0]      cnt;

  // EMA sum and rounding
  logic signed [42:0] ema_sum;
  assign ema_sum = $signed({prod_new[33], prod_new, 8'd0})
                 + $signed({prod_old[41], prod_old})
                 + 43'sd32768;

  // Turn step and unwrapped angle
  logic [12:0]        angle;
  logic signed [13:0] diff;
  logic signed [13:0] thr_pos;
  logic [15:0]        turns_next;
  logic [32:0]        turns_ext;
  logic signed [32:0] total;
  logic signed [33:0] delta;
  logic [33:0]        mag;
  assign angle   = req.rotor_angle & AMASK;
  assign diff    = $signed({1'b0, angle}) - $signed({1'b0, previous_angle[idx]});
  assign thr_pos = $signed({1'b0, thr_eff});
  always_comb begin
    turns_next = turns[idx];
    if (diff <= -thr_pos)     turns_next = turns[idx] + 16'd1;
    else if (diff >= thr_pos) turns_next = turns[idx] - 16'd1;
  end
  assign turns_ext = {{17{turns_next[15]}}, turns_next} << ANGLE_BITS;
  assign total = $signed(turns_ext) + $signed({20'd0, angle});
  assign delta = started[idx] ? ($signed({total[32], total})
                                 - $signed({zero_offset[idx][32], zero_offset[idx]}))
                              : 34'sd0;
  assign mag = delta[33] ? 34'(-delta) : 34'(delta);

  // Restoring remainder step
  logic [30:0] rem_shift;
  assign rem_shift = {rem, dividend[mfat_pkg::DIV_BITS-1]};
  assign sts.div_last = (cnt == CW'(mfat_pkg::DIV_BITS - 1));
  assign sts.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_data;
      idx <= IW'(in_data.motor_number - 4'd1);
    end
    if (cmd.mul_new)
      prod_new <= req.speed_sample * $signed({1'b0, w_eff});
    if (cmd.mul_old)
      prod_old <= speed_average[idx] * $signed({1'b0, 17'(mfat_pkg::WEIGHT_ONE - w_eff)});
    if (cmd.update) begin
      avg_res  <= ema_sum[39:16];
      neg      <= delta[33];
      dividend <= {mag, 8'd0};
      rem      <= 30'd0;
      cnt      <= '0;
    end
    if (cmd.div_step) begin
      rem      <= (rem_shift >= {1'b0, span_eff}) ? 30'(rem_shift - {1'b0, span_eff})
                                                  : rem_shift[29:0];
      dividend <= dividend << 1;
      cnt      <= cnt + CW'(1);
    end
  end

  // State write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        speed_average[i]  <= '0;
        previous_angle[i] <= '0;
        turns[i]          <= '0;
        zero_offset[i]    <= '0;
        started[i]        <= 1'b0;
      end
    end else if (cmd.update) begin
      speed_average[idx]  <= ema_sum[39:16];
      previous_angle[idx] <= angle;
      turns[idx]          <= turns_next;
      started[idx]        <= 1'b1;
      if (!started[idx]) zero_offset[idx] <= total;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.motor_out      <= req.motor_number;
      out_data.filtered_speed <= avg_res;
      out_data.turn_count     <= turns[idx];
      out_data.zeroed_angle   <= (neg && rem != 30'd0) ? 30'(span_eff - rem) : rem;
      out_data.current_out    <= req.current_sample;
    end
  end

  // A result is written only into a free output slot
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !sts.out_busy) else $error("result overwrote pending output");
  // Remainder stays below the span
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> rem < span_eff) else $error("remainder out of range");
  // Finish always raises valid
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("finish without valid");

endmodule
`default_nettype wire

@@ hw/rtl/mfat_controller.sv @@
// Controller: sequences one request through the datapath.
`default_nettype none
module mfat_controller (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  mfat_pkg::sts_t sts,
  output mfat_pkg::cmd_t       cmd
);

  mfat_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= mfat_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      mfat_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.motor_ok) state_next = mfat_pkg::ST_MUL_NEW;
        end
      end
      mfat_pkg::ST_MUL_NEW: begin
        cmd.mul_new = 1'b1;
        state_next  = mfat_pkg::ST_MUL_OLD;
      end
      mfat_pkg::ST_MUL_OLD: begin
        cmd.mul_old = 1'b1;
        state_next  = mfat_pkg::ST_UPDATE;
      end
      mfat_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = mfat_pkg::ST_DIV;
      end
      mfat_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = mfat_pkg::ST_FINISH;
      end
      mfat_pkg::ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = mfat_pkg::ST_IDLE;
        end
      end
      default: state_next = mfat_pkg::ST_IDLE;
    endcase
  end

  // Only one datapath command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("overlapping commands");
  // Division always follows the state update
  a_div_order: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> cmd.div_step) else $error("division did not start");
  // No request taken while busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != mfat_pkg::ST_IDLE) |-> !in_ready) else $error("ready while busy");

endmodule
`default_nettype wire

@@ hw/rtl/motor_feedback_angle_tracker.sv @@
// Motor feedback angle tracker: per-motor speed EMA, turn count, zeroed angle.
// Each request goes through two multiplies, the state update and a 42-step remainder.
// A new request is taken only after the previous one is finished in the bit-serial remainder unit.
// Out-of-range motor numbers are accepted and give no result.
// A new request is taken while the previous result waits in the output register.
// Synchronous reset restores register defaults and clears all per-motor state.
`default_nettype none
module motor_feedback_angle_tracker #(
  parameter int MOTOR_COUNT = 8,
  parameter int ANGLE_BITS  = 13
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  mfat_pkg::in_t        in_data,
  output logic                       out_valid,
  input  wire                        out_ready,
  output mfat_pkg::out_t             out_data,
  input  wire                        cfg_we,
  input  wire  [1:0]                 cfg_index,
  input  wire  [mfat_pkg::CFG_W-1:0] cfg_data
);

  mfat_pkg::cmd_t cmd;
  mfat_pkg::sts_t sts;

  mfat_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfat_datapath #(
    .MOTOR_COUNT (MOTOR_COUNT),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ sim/mfat_checker.sv @@
// Checker for the motor feedback angle tracker: predicts results and compares them.
`timescale 1ns / 1ps
module mfat_checker (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire                 in_ready,
  input  mfat_pkg::in_t       in_data,
  input  wire                 out_valid,
  input  wire                 out_ready,
  input  mfat_pkg::out_t      out_data,
  input  wire                 cfg_we,
  input  wire  [1:0]          cfg_index,
  input  wire  [29:0]         cfg_data,
  output int                  fail_count,
  output int                  pending
);

  localparam int MOTORS = 8;
  localparam int ABITS = 13;

  // Shadow copy of the registers
  logic [16:0] weight;
  logic [12:0] threshold;
  logic [29:0] span;

  // Shadow copy of the per-motor state
  logic signed [23:0] avg_speed [MOTORS];
  logic [12:0]        last_angle [MOTORS];
  logic [15:0]        turn_cnt [MOTORS];
  longint             zero_pos [MOTORS];
  bit                 seen [MOTORS];

  mfat_pkg::out_t expected_results[$];

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Work out the result of one frame and advance the shadow state
  function automatic void track_frame(input mfat_pkg::in_t f);
    int m;
    longint w, acc, spd, diff, thr, total, sp, rel;
    mfat_pkg::out_t r;
    if (f.motor_number < 1 || f.motor_number > MOTORS) return;
    m = f.motor_number - 1;
    spd = longint'(f.speed_sample);
    w = (weight > 17'd65536) ? 65536 : longint'(weight);
    acc = spd * 256 * w + longint'(avg_speed[m]) * (65536 - w);
    avg_speed[m] = 24'((acc + 32768) >>> 16);
    thr = (threshold == 0) ? 1 : longint'(threshold);
    diff = longint'(f.rotor_angle) - longint'(last_angle[m]);
    if (diff <= -thr) turn_cnt[m] = turn_cnt[m] + 16'd1;
    else if (diff >= thr) turn_cnt[m] = turn_cnt[m] - 16'd1;
    last_angle[m] = f.rotor_angle;
    total = longint'(f.rotor_angle) + longint'($signed(turn_cnt[m])) * (64'sd1 << ABITS);
    if (!seen[m]) begin
      seen[m] = 1'b1;
      zero_pos[m] = total;
    end
    sp = (span < 30'd256) ? 256 : longint'(span);
    rel = ((total - zero_pos[m]) * 256) % sp;
    if (rel < 0) rel += sp;
    r.motor_out = f.motor_number;
    r.filtered_speed = avg_speed[m];
    r.turn_count = turn_cnt[m];
    r.zeroed_angle = 30'(rel);
    r.current_out = f.current_sample;
    expected_results.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      weight = mfat_pkg::WEIGHT_RST;
      threshold = mfat_pkg::THR_RST;
      span = mfat_pkg::SPAN_RST;
      for (int i = 0; i < MOTORS; i++) begin
        avg_speed[i] = '0;
        last_angle[i] = '0;
        turn_cnt[i] = '0;
        zero_pos[i] = 0;
        seen[i] = 1'b0;
      end
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mfat_pkg::REG_EMA_WEIGHT: weight = cfg_data[16:0];
          mfat_pkg::REG_JUMP_THR:   threshold = cfg_data[12:0];
          mfat_pkg::REG_OUT_SPAN:   span = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) track_frame(in_data);
      // Compare each result with the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result, motor", out_data.motor_out, 0);
        end else begin
          mfat_pkg::out_t e;
          e = expected_results.pop_front();
          if (out_data.motor_out != e.motor_out)
            report("motor_out", out_data.motor_out, e.motor_out);
          if (out_data.filtered_speed != e.filtered_speed)
            report("filtered_speed", out_data.filtered_speed, e.filtered_speed);
          if (out_data.turn_count != e.turn_count)
            report("turn_count", out_data.turn_count, e.turn_count);
          if (out_data.zeroed_angle != e.zeroed_angle)
            report("zeroed_angle", out_data.zeroed_angle, e.zeroed_angle);
          if (out_data.current_out != e.current_out)
            report("current_out", out_data.current_out, e.current_out);
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

@@ sim/tb_top.sv @@
// Testbench top for the motor feedback angle tracker: stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  mfat_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  mfat_pkg::out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [29:0] cfg_data;
  int fail_count;
  int pending;
  int idle_cycles;
  bit stim_done;

  motor_feedback_angle_tracker dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mfat_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Send one request, with a random gap ahead of it; valid stays up for back to back
  task automatic send_frame(input logic [3:0] motor, input logic [12:0] angle,
                            input logic [15:0] speed, input logic [15:0] current);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{motor, angle, speed, current};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(input bit well_formed);
    logic [3:0] motor;
    motor = well_formed ? 4'($urandom_range(1, 8)) : 4'($urandom);
    send_frame(motor, 13'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Let the block drain before a register write
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [29:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver draws a stall before each result, sometimes none at all
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = mfat_pkg::REG_EMA_WEIGHT;
    cfg_data = '0;
    stim_done = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, field extremes, wrap in both directions
    send_frame(4'd1, 13'd0, 16'h7FFF, 16'h7FFF);
    send_frame(4'd1, 13'd8191, 16'h8000, 16'h8000);
    send_frame(4'd1, 13'd0, 16'h8000, 16'h0000);
    send_frame(4'd1, 13'd100, 16'hFFFF, 16'hFFFF);
    send_frame(4'd8, 13'd8191, 16'h7FFF, 16'h1234);
    send_frame(4'd8, 13'd8191, 16'h0000, 16'h0000);
    // Out-of-range motors are dropped
    send_frame(4'd0, 13'd55, 16'h0001, 16'h0001);
    send_frame(4'd9, 13'd55, 16'h0001, 16'h0001);
    send_frame(4'd15, 13'd8191, 16'hFFFF, 16'hFFFF);
    send_frame(4'd2, 13'd4096, 16'h0100, 16'h0002);
    wait_idle();
    // Extremes: full weight, zero threshold, small span
    write_reg(mfat_pkg::REG_EMA_WEIGHT, 30'd65536);
    write_reg(mfat_pkg::REG_JUMP_THR, 30'd0);
    write_reg(mfat_pkg::REG_OUT_SPAN, 30'd0);
    send_frame(4'd2, 13'd4097, 16'h7FFF, 16'h0003);
    send_frame(4'd2, 13'd4096, 16'h8000, 16'h0004);
    send_frame(4'd3, 13'd1, 16'h4000, 16'h0005);
    wait_idle();
    write_reg(mfat_pkg::REG_EMA_WEIGHT, 30'h1FFFF);
    write_reg(mfat_pkg::REG_JUMP_THR, 30'd8191);
    write_reg(mfat_pkg::REG_OUT_SPAN, 30'h3FFFFFFF);
    send_frame(4'd3, 13'd8191, 16'h7FFF, 16'h0006);
    send_frame(4'd3, 13'd0, 16'h1111, 16'h0007);
    send_frame(4'd4, 13'd8000, 16'h8001, 16'h0008);
    wait_idle();
    write_reg(mfat_pkg::REG_EMA_WEIGHT, 30'd0);
    write_reg(mfat_pkg::REG_JUMP_THR, 30'd1);
    write_reg(mfat_pkg::REG_OUT_SPAN, 30'd255);
    send_frame(4'd4, 13'd0, 16'h7FFF, 16'h0009);
    send_frame(4'd5, 13'd3, 16'h8000, 16'h000A);
    wait_idle();

    // Random phases with fresh settings each time
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(mfat_pkg::REG_EMA_WEIGHT, 30'($urandom_range(0, 65540)));
      write_reg(mfat_pkg::REG_JUMP_THR,
                (phase % 2) ? 30'($urandom_range(4000, 8191)) : 30'($urandom));
      write_reg(mfat_pkg::REG_OUT_SPAN,
                (phase == 5) ? 30'($urandom) : 30'($urandom_range(256, 5000000)));
      for (int n = 0; n < 72; n++)
        send_random($urandom_range(0, 9) != 0);
      wait_idle();
    end
    stim_done = 1'b1;
  end

  // Verdict once stimulus and results are done
  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

@@ motor_feedback_angle_tracker.f @@
hw/rtl/mfat_pkg.sv
hw/rtl/mfat_datapath.sv
hw/rtl/mfat_controller.sv
hw/rtl/motor_feedback_angle_tracker.sv
sim/mfat_checker.sv
sim/tb_top.sv
